/* src/sha1_message_digest_defines.svh */
// Assertion macros for the SHA-1 digest block.
// Taken in by the files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sha1_pkg.sv */
// Shared types and constants for the SHA-1 digest block.
// No dependencies; used by the round unit and the top level.
package sha1_pkg;

  // Five 32-bit words: working variables a..e, or chaining words h0..h4.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } vars_t;

  localparam logic [31:0] IV0 = 32'h6745_2301;
  localparam logic [31:0] IV1 = 32'hEFCD_AB89;
  localparam logic [31:0] IV2 = 32'h98BA_DCFE;
  localparam logic [31:0] IV3 = 32'h1032_5476;
  localparam logic [31:0] IV4 = 32'hC3D2_E1F0;

  localparam vars_t CHAIN_INIT = '{a: IV0, b: IV1, c: IV2, d: IV3, e: IV4};

  localparam logic [31:0] K_R0 = 32'h5A82_7999;
  localparam logic [31:0] K_R1 = 32'h6ED9_EBA1;
  localparam logic [31:0] K_R2 = 32'h8F1B_BCDC;
  localparam logic [31:0] K_R3 = 32'hCA62_C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned ROUNDS = 80;
  localparam int unsigned BLOCK_WORDS = 16;

endpackage

/* src/sha1_if.sv */
// Valid/ready channel interfaces for the SHA-1 digest block.
// Depends on nothing; one interface per channel direction of payload.
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output has_byte, output is_last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input is_last,
                  output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, output digest_word4,
                  input ready);
  modport sink   (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, input digest_word4,
                  output ready);
endinterface

/* src/sha1_message_digest.sv */
// SHA-1 digest top level: byte packing, padding sequencer, shared round unit.
// Depends on sha1_pkg, sha1_if (channels), sha1_round, sha1_message_digest_defines.svh.
//
//  channel | dir | payload                        | beat
//  in_bus  | in  | data_byte[8] has_byte is_last  | one message byte or end marker
//  out_bus | out | digest_word0..digest_word4[32] | one digest per message
//
// A plain byte beat leaves in_bus ready; a beat that fills the 64-byte block first
// runs the 80 rounds on the one round unit and one chaining add. An end beat pads
// one byte per cycle outside compressions, places the length, compresses one or two
// blocks and loads the digest before in_bus is ready again.
// Reset restores the initial chaining words and clears the length and fill.
// A stalled out_bus blocks only once a second digest waits to load.
module sha1_message_digest (
  input  logic              clk,
  input  logic              rst_n,
  sha1_in_if.sink           in_bus,
  sha1_out_if.source        out_bus
);
  import sha1_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;  // taking beats
  localparam logic [2:0] S_PAD80 = 3'd1;  // append the 0x80 marker
  localparam logic [2:0] S_ZPAD  = 3'd2;  // zero fill, then length
  localparam logic [2:0] S_COMP  = 3'd3;  // 80 rounds
  localparam logic [2:0] S_FIN   = 3'd4;  // chaining add
  localparam logic [2:0] S_EMIT  = 3'd5;  // load the digest register

  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [6:0] LAST_RND  = 7'(ROUNDS - 1);
  localparam logic [63:0] BYTE_BITS = 64'd8;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  after_r, after_nxt;   // where to go once a compression finishes
  logic [6:0]  round_r, round_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  vars_t       h_r, h_nxt;
  vars_t       v_r, v_nxt;
  logic [31:0] w_r   [BLOCK_WORDS];  // block words, then the schedule window
  logic [31:0] w_nxt [BLOCK_WORDS];

  logic        out_valid_r, out_valid_nxt;
  vars_t       dig_r, dig_nxt;

  vars_t       v_round;
  logic [31:0] sched_new;

  logic        in_take;
  logic        put_en;
  logic [7:0]  put_byte;
  logic [31:0] put_word;
  logic [5:0]  fill_inc;

  sha1_round u_round (
    .round_i (round_r),
    .vars_i  (v_r),
    .w0_i    (w_r[0]),
    .w2_i    (w_r[2]),
    .w8_i    (w_r[8]),
    .w13_i   (w_r[13]),
    .vars_o  (v_round),
    .sched_o (sched_new)
  );

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_take      = in_bus.valid && in_bus.ready;
  assign fill_inc     = fill_r + 6'd1;

  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    round_nxt     = round_r;
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    dig_nxt       = dig_r;
    out_valid_nxt = out_valid_r && !out_bus.ready;
    put_en        = 1'b0;
    put_byte      = 8'd0;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_bus.has_byte) begin
            put_en   = 1'b1;
            put_byte = in_bus.data_byte;
            bits_nxt = bits_r + BYTE_BITS;
          end
          if (in_bus.has_byte && fill_inc == 6'd0) begin
            state_nxt = S_COMP;
            after_nxt = in_bus.is_last ? S_PAD80 : S_IDLE;
          end else if (in_bus.is_last) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        put_en    = 1'b1;
        put_byte  = PAD_BYTE;
        state_nxt = S_ZPAD;
        if (fill_inc == 6'd0) begin
          state_nxt = S_COMP;
          after_nxt = S_ZPAD;
        end
      end
      S_ZPAD: begin
        if (fill_r == LEN_POS) begin
          w_nxt[14] = bits_r[63:32];
          w_nxt[15] = bits_r[31:0];
          state_nxt = S_COMP;
          after_nxt = S_EMIT;
        end else begin
          put_en = 1'b1;
          if (fill_inc == 6'd0) begin
            state_nxt = S_COMP;
            after_nxt = S_ZPAD;
          end
        end
      end
      S_COMP: begin
        v_nxt     = v_round;
        round_nxt = round_r + 7'd1;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[BLOCK_WORDS-1] = sched_new;
        if (round_r == LAST_RND) begin
          round_nxt = 7'd0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        h_nxt.a   = h_r.a + v_r.a;
        h_nxt.b   = h_r.b + v_r.b;
        h_nxt.c   = h_r.c + v_r.c;
        h_nxt.d   = h_r.d + v_r.d;
        h_nxt.e   = h_r.e + v_r.e;
        state_nxt = after_r;
      end
      S_EMIT: begin
        if (!out_valid_r || out_bus.ready) begin
          dig_nxt       = h_r;
          out_valid_nxt = 1'b1;
          h_nxt         = CHAIN_INIT;
          bits_nxt      = 64'd0;
          fill_nxt      = 6'd0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Byte lane 0 opens a fresh word; later lanes merge into it.
    put_word = w_r[fill_r[5:2]] | ({24'd0, put_byte} << {2'd3 - fill_r[1:0], 3'b000});
    if (fill_r[1:0] == 2'd0) begin
      put_word = {put_byte, 24'd0};
    end

    if (put_en) begin
      w_nxt[fill_r[5:2]] = put_word;
      fill_nxt           = fill_inc;
    end

    // Every entry into the rounds starts from the current chaining words.
    if (state_r != S_COMP && state_nxt == S_COMP) begin
      v_nxt     = h_r;
      round_nxt = 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_IDLE;
      round_r     <= 7'd0;
      fill_r      <= 6'd0;
      bits_r      <= 64'd0;
      h_r         <= CHAIN_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      round_r     <= round_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    w_r   <= w_nxt;
    dig_r <= dig_nxt;
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.digest_word0 = dig_r.a;
  assign out_bus.digest_word1 = dig_r.b;
  assign out_bus.digest_word2 = dig_r.c;
  assign out_bus.digest_word3 = dig_r.d;
  assign out_bus.digest_word4 = dig_r.e;

`include "sha1_message_digest_defines.svh"

  `SHA1_ASSERT_NOW(a_round_range, state_r == S_COMP, round_r <= LAST_RND, "round out of range")
  `SHA1_ASSERT_NOW(a_fin_after_comp, state_r == S_FIN, round_r == 7'd0 && $past(state_r) == S_COMP, "chaining add without rounds")
  `SHA1_ASSERT_NOW(a_emit_len_pos, state_r == S_EMIT, fill_r == LEN_POS, "digest before length block")
  `SHA1_ASSERT_NEXT(a_emit_clears, state_r == S_EMIT && state_nxt == S_IDLE, out_valid_r && fill_r == 6'd0 && bits_r == 64'd0, "message state not cleared on digest")

endmodule

/* src/sha1_round.sv */
// SHA-1 round datapath: one round of the compression and one schedule word.
// Depends on sha1_pkg (vars_t, round constants).
module sha1_round (
  input  logic [6:0]      round_i,
  input  sha1_pkg::vars_t vars_i,
  input  logic [31:0]     w0_i,
  input  logic [31:0]     w2_i,
  input  logic [31:0]     w8_i,
  input  logic [31:0]     w13_i,
  output sha1_pkg::vars_t vars_o,
  output logic [31:0]     sched_o
);
  import sha1_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] x;

  always_comb begin
    if (round_i inside {[7'd0:7'd19]}) begin
      f = (vars_i.b & vars_i.c) | (~vars_i.b & vars_i.d);
      k = K_R0;
    end else if (round_i inside {[7'd20:7'd39]}) begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K_R1;
    end else if (round_i inside {[7'd40:7'd59]}) begin
      f = (vars_i.b & vars_i.c) | (vars_i.b & vars_i.d) | (vars_i.c & vars_i.d);
      k = K_R2;
    end else begin
      f = vars_i.b ^ vars_i.c ^ vars_i.d;
      k = K_R3;
    end
  end

  assign vars_o.a = {vars_i.a[26:0], vars_i.a[31:27]} + f + vars_i.e + k + w0_i;
  assign vars_o.b = vars_i.a;
  assign vars_o.c = {vars_i.b[1:0], vars_i.b[31:2]};
  assign vars_o.d = vars_i.c;
  assign vars_o.e = vars_i.d;

  // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t])
  assign x       = w13_i ^ w8_i ^ w2_i ^ w0_i;
  assign sched_o = {x[30:0], x[31]};

endmodule
